>>> design/assert_macros.svh
// Assertion macros used by the checker file of this project.
// Each macro names the assertion, samples on the rising clock edge and is
// disabled while the active-low reset is asserted.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication: when ante holds, cons must hold at the same edge.
`define BBEF_ASSERT_IMPL(label, ck, rn, ante, cons, msg) \
	label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication: when ante holds, cons must hold at the next edge.
`define BBEF_ASSERT_NEXT(label, ck, rn, ante, cons, msg) \
	label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> design/bbef_pkg.sv
// ----------------------------------------------------------------------------
// bbef_pkg
// Types, codes and helper functions shared by the boundary extreme finder.
// ----------------------------------------------------------------------------
package bbef_pkg;

	localparam int IDX_W = 8;
	localparam int SIZE_W = 9;
	localparam int FRAME_MAX = 256;
	localparam int DEF_MAX_WIDTH = 256;
	localparam int DEF_MAX_HEIGHT = 256;
	localparam int APB_AW = 3;
	localparam int APB_DW = 32;
	localparam int EXT_W = 2 * IDX_W;

	localparam logic [1:0] OP_WRITE = 2'd0;
	localparam logic [1:0] OP_COMPUTE = 2'd1;
	localparam logic [1:0] OP_QUERY = 2'd2;
	localparam logic [1:0] OP_RSVD = 2'd3;

	localparam logic REG_FRAME_WIDTH = 1'b0;
	localparam logic REG_FRAME_HEIGHT = 1'b1;

	localparam logic [SIZE_W-1:0] FRAME_RESET = 9'd256;

	// Selects which window row a pixel memory read fills.
	localparam logic [1:0] RD_NONE = 2'd0;
	localparam logic [1:0] RD_PREV = 2'd1;
	localparam logic [1:0] RD_CUR = 2'd2;
	localparam logic [1:0] RD_NEXT = 2'd3;

	typedef struct packed {
		logic [1:0] op;
		logic [IDX_W-1:0] row;
		logic [IDX_W-1:0] col;
		logic pixel;
	} bbef_item_t;

	typedef struct packed {
		logic row_found;
		logic [IDX_W-1:0] row_first_col;
		logic [IDX_W-1:0] row_last_col;
		logic col_found;
		logic [IDX_W-1:0] col_first_row;
		logic [IDX_W-1:0] col_last_row;
		logic edge_bit;
		logic boundary_bit;
		logic out_of_range;
		logic done_res;
	} bbef_res_t;

	typedef struct packed {
		logic take;
		logic row_zero;
		logic row_inc;
		logic col_zero;
		logic col_inc;
		logic clear_found;
		logic [1:0] pix_rd;
		logic pix_wr;
		logic ext_rd;
		logic px_update;
		logic row_commit;
		logic load_res;
	} bbef_cmd_t;

	typedef struct packed {
		logic [1:0] op;
		logic oor;
		logic last_col;
		logic last_row;
	} bbef_sts_t;

	// Frame size register limited to 1..cap.
	function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] val,
			input logic [SIZE_W-1:0] cap);
		logic [SIZE_W-1:0] v;
		v = val;
		if (v == '0) v = SIZE_W'(1);
		if (v > cap) v = cap;
		return v;
	endfunction

	// 3x3 neighbourhood, row major from the upper left; nb[4] is the centre.
	// A neighbour only counts where its direction flags say it is in the frame.
	function automatic logic edge_of(input logic [8:0] nb, input logic up,
			input logic dn, input logic lf, input logic rt);
		logic [7:0] nbr;
		logic [7:0] vld;
		nbr = {nb[8], nb[7], nb[6], nb[5], nb[3], nb[2], nb[1], nb[0]};
		vld = {dn & rt, dn, dn & lf, rt, lf, up & rt, up, up & lf};
		return |((nbr ^ {8{nb[4]}}) & vld);
	endfunction

endpackage

>>> design/bbef_ifs.sv
// ----------------------------------------------------------------------------
// bbef_req_if / bbef_rsp_if
// Valid/ready channels for command items and result items.
// ----------------------------------------------------------------------------
interface bbef_req_if;
	logic valid;
	logic ready;
	logic [1:0] op;
	logic [bbef_pkg::IDX_W-1:0] row;
	logic [bbef_pkg::IDX_W-1:0] col;
	logic pixel;

	modport source(output valid, output op, output row, output col, output pixel,
		input ready);
	modport sink(input valid, input op, input row, input col, input pixel,
		output ready);
endinterface

interface bbef_rsp_if;
	logic valid;
	logic ready;
	logic row_found;
	logic [bbef_pkg::IDX_W-1:0] row_first_col;
	logic [bbef_pkg::IDX_W-1:0] row_last_col;
	logic col_found;
	logic [bbef_pkg::IDX_W-1:0] col_first_row;
	logic [bbef_pkg::IDX_W-1:0] col_last_row;
	logic edge_bit;
	logic boundary_bit;
	logic out_of_range;
	logic done_res;

	modport source(output valid, output row_found, output row_first_col,
		output row_last_col, output col_found, output col_first_row,
		output col_last_row, output edge_bit, output boundary_bit,
		output out_of_range, output done_res, input ready);
	modport sink(input valid, input row_found, input row_first_col,
		input row_last_col, input col_found, input col_first_row,
		input col_last_row, input edge_bit, input boundary_bit,
		input out_of_range, input done_res, output ready);
endinterface

>>> design/bbef_ram.sv
// ----------------------------------------------------------------------------
// bbef_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module bbef_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input logic clk,
	input logic wr_en,
	input logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input logic [WIDTH-1:0] wr_data,
	input logic rd_en,
	input logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic [WIDTH-1:0] rd_data
);
	logic [WIDTH-1:0] mem [DEPTH];

	// Read data holds its value between reads.
	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= wr_data;
		if (rd_en) rd_data <= mem[rd_addr];
	end
endmodule

>>> design/bbef_ctrl.sv
// ----------------------------------------------------------------------------
// bbef_ctrl
// Sequencer for pixel writes, the boundary walk and queries.
// ----------------------------------------------------------------------------
module bbef_ctrl (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input logic out_ready,
	output bbef_pkg::bbef_cmd_t cmd,
	input bbef_pkg::bbef_sts_t sts
);
	import bbef_pkg::*;

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_DECODE = 4'd1;
	localparam logic [3:0] S_CLR = 4'd2;
	localparam logic [3:0] S_LD_PREV = 4'd3;
	localparam logic [3:0] S_LD_CUR = 4'd4;
	localparam logic [3:0] S_LD_NEXT = 4'd5;
	localparam logic [3:0] S_LD_WAIT = 4'd6;
	localparam logic [3:0] S_WR = 4'd7;
	localparam logic [3:0] S_PX_RD = 4'd8;
	localparam logic [3:0] S_PX_UPD = 4'd9;
	localparam logic [3:0] S_ROW_END = 4'd10;
	localparam logic [3:0] S_RESULT = 4'd11;

	logic [3:0] state_q;
	logic [3:0] state_d;
	logic out_valid_q;

	assign in_ready = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd = '0;
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.take = 1'b1;
					state_d = S_DECODE;
				end
			end
			S_DECODE: begin
				if (sts.op == OP_COMPUTE) begin
					state_d = S_CLR;
				end else if ((sts.op inside {OP_WRITE, OP_QUERY}) && !sts.oor) begin
					state_d = S_LD_PREV;
				end else begin
					state_d = S_RESULT;
				end
			end
			S_CLR: begin
				cmd.clear_found = 1'b1;
				cmd.row_zero = 1'b1;
				state_d = S_LD_PREV;
			end
			S_LD_PREV: begin
				cmd.pix_rd = RD_PREV;
				cmd.ext_rd = 1'b1;
				cmd.col_zero = (sts.op == OP_COMPUTE);
				state_d = S_LD_CUR;
			end
			S_LD_CUR: begin
				cmd.pix_rd = RD_CUR;
				state_d = S_LD_NEXT;
			end
			S_LD_NEXT: begin
				cmd.pix_rd = RD_NEXT;
				state_d = S_LD_WAIT;
			end
			S_LD_WAIT: begin
				case (sts.op)
					OP_WRITE: state_d = S_WR;
					OP_COMPUTE: state_d = S_PX_RD;
					default: state_d = S_RESULT;
				endcase
			end
			S_WR: begin
				cmd.pix_wr = 1'b1;
				state_d = S_RESULT;
			end
			S_PX_RD: begin
				cmd.ext_rd = 1'b1;
				state_d = S_PX_UPD;
			end
			S_PX_UPD: begin
				cmd.px_update = 1'b1;
				if (sts.last_col) begin
					state_d = S_ROW_END;
				end else begin
					cmd.col_inc = 1'b1;
					state_d = S_PX_RD;
				end
			end
			S_ROW_END: begin
				cmd.row_commit = 1'b1;
				if (sts.last_row) begin
					state_d = S_RESULT;
				end else begin
					cmd.row_inc = 1'b1;
					state_d = S_LD_PREV;
				end
			end
			S_RESULT: begin
				if (!out_valid_q || out_ready) begin
					cmd.load_res = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_res) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end
endmodule

>>> design/bbef_dp.sv
// ----------------------------------------------------------------------------
// bbef_dp
// Pixel memory with a three-row window, edge test, extreme tables and the
// result register.
// ----------------------------------------------------------------------------
module bbef_dp #(
	parameter int MAX_WIDTH = bbef_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = bbef_pkg::DEF_MAX_HEIGHT
) (
	input logic clk,
	input logic arst_n,
	input bbef_pkg::bbef_cmd_t cmd,
	output bbef_pkg::bbef_sts_t sts,
	input bbef_pkg::bbef_item_t item,
	input logic [bbef_pkg::SIZE_W-1:0] frame_width,
	input logic [bbef_pkg::SIZE_W-1:0] frame_height,
	output bbef_pkg::bbef_res_t res
);
	import bbef_pkg::*;

	localparam int COLS = (MAX_WIDTH < FRAME_MAX) ? MAX_WIDTH : FRAME_MAX;
	localparam int ROWS = (MAX_HEIGHT < FRAME_MAX) ? MAX_HEIGHT : FRAME_MAX;
	localparam int CW = $clog2(COLS);
	localparam int RW = $clog2(ROWS);

	logic [SIZE_W-1:0] w_eff;
	logic [SIZE_W-1:0] h_eff;

	logic [1:0] op_q;
	logic pixel_q;
	logic [IDX_W-1:0] row_q;
	logic [IDX_W-1:0] col_q;

	logic [COLS-1:0] win_prev_q;
	logic [COLS-1:0] win_cur_q;
	logic [COLS-1:0] win_next_q;
	logic [1:0] rd_sel_s1;

	logic [ROWS-1:0] row_found_q;
	logic [COLS-1:0] col_found_q;

	logic rx_found_q;
	logic [IDX_W-1:0] rx_first_q;
	logic [IDX_W-1:0] rx_last_q;

	logic oor;
	logic last_col;
	logic last_row;
	logic [IDX_W-1:0] up_row;
	logic [IDX_W-1:0] dn_row;
	logic [IDX_W-1:0] lf_col;
	logic [IDX_W-1:0] rt_col;
	logic [IDX_W-1:0] pix_addr;
	logic [CW-1:0] ci;
	logic [CW-1:0] cl;
	logic [CW-1:0] cr;
	logic [RW-1:0] ri;
	logic [8:0] nb;
	logic edge_w;
	logic [COLS-1:0] new_row;
	logic [COLS-1:0] pix_rdata;
	logic [EXT_W-1:0] row_rdata;
	logic [EXT_W-1:0] col_rdata;
	logic [EXT_W-1:0] col_wdata;
	logic [IDX_W-1:0] col_first_new;
	logic row_hit;
	logic col_hit;
	bbef_res_t res_d;
	bbef_res_t res_q;

	assign w_eff = eff_size(frame_width, SIZE_W'(COLS));
	assign h_eff = eff_size(frame_height, SIZE_W'(ROWS));

	assign oor = ({1'b0, row_q} >= h_eff) || ({1'b0, col_q} >= w_eff);
	assign last_col = ({1'b0, col_q} + SIZE_W'(1)) == w_eff;
	assign last_row = ({1'b0, row_q} + SIZE_W'(1)) == h_eff;

	assign sts.op = op_q;
	assign sts.oor = oor;
	assign sts.last_col = last_col;
	assign sts.last_row = last_row;

	// Neighbour indexes are clamped into the frame; the direction flags
	// below mask whatever a clamped index reads.
	assign up_row = (row_q == '0) ? row_q : row_q - IDX_W'(1);
	assign dn_row = last_row ? row_q : row_q + IDX_W'(1);
	assign lf_col = (col_q == '0) ? col_q : col_q - IDX_W'(1);
	assign rt_col = last_col ? col_q : col_q + IDX_W'(1);

	assign ci = col_q[CW-1:0];
	assign cl = lf_col[CW-1:0];
	assign cr = rt_col[CW-1:0];
	assign ri = row_q[RW-1:0];

	assign nb = {win_next_q[cr], win_next_q[ci], win_next_q[cl],
		win_cur_q[cr], win_cur_q[ci], win_cur_q[cl],
		win_prev_q[cr], win_prev_q[ci], win_prev_q[cl]};
	assign edge_w = edge_of(nb, row_q != '0, !last_row, col_q != '0, !last_col);

	always_comb begin
		case (cmd.pix_rd)
			RD_PREV: pix_addr = up_row;
			RD_NEXT: pix_addr = dn_row;
			default: pix_addr = row_q;
		endcase
	end

	always_comb begin
		new_row = win_cur_q;
		new_row[ci] = pixel_q;
	end

	bbef_ram #(
		.WIDTH(COLS),
		.DEPTH(ROWS)
	) u_pix_ram (
		.clk(clk),
		.wr_en(cmd.pix_wr),
		.wr_addr(ri),
		.wr_data(new_row),
		.rd_en(cmd.pix_rd != RD_NONE),
		.rd_addr(pix_addr[RW-1:0]),
		.rd_data(pix_rdata)
	);

	bbef_ram #(
		.WIDTH(EXT_W),
		.DEPTH(ROWS)
	) u_row_ext_ram (
		.clk(clk),
		.wr_en(cmd.row_commit && rx_found_q),
		.wr_addr(ri),
		.wr_data({rx_first_q, rx_last_q}),
		.rd_en(cmd.ext_rd),
		.rd_addr(ri),
		.rd_data(row_rdata)
	);

	// A column's first edge row is kept once found; its last moves with the walk.
	assign col_first_new = col_found_q[ci] ? col_rdata[EXT_W-1:IDX_W] : row_q;
	assign col_wdata = {col_first_new, row_q};

	bbef_ram #(
		.WIDTH(EXT_W),
		.DEPTH(COLS)
	) u_col_ext_ram (
		.clk(clk),
		.wr_en(cmd.px_update && edge_w),
		.wr_addr(ci),
		.wr_data(col_wdata),
		.rd_en(cmd.ext_rd),
		.rd_addr(ci),
		.rd_data(col_rdata)
	);

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			op_q <= item.op;
			pixel_q <= item.pixel;
		end
		if (cmd.take) begin
			row_q <= item.row;
		end else if (cmd.row_zero) begin
			row_q <= '0;
		end else if (cmd.row_inc) begin
			row_q <= row_q + IDX_W'(1);
		end
		if (cmd.take) begin
			col_q <= item.col;
		end else if (cmd.col_zero) begin
			col_q <= '0;
		end else if (cmd.col_inc) begin
			col_q <= col_q + IDX_W'(1);
		end
		case (rd_sel_s1)
			RD_PREV: win_prev_q <= pix_rdata;
			RD_CUR: win_cur_q <= pix_rdata;
			RD_NEXT: win_next_q <= pix_rdata;
			default: ;
		endcase
		if (cmd.px_update && edge_w) begin
			if (!rx_found_q) rx_first_q <= col_q;
			rx_last_q <= col_q;
		end
		if (cmd.load_res) res_q <= res_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_sel_s1 <= RD_NONE;
			rx_found_q <= 1'b0;
			row_found_q <= '0;
			col_found_q <= '0;
		end else begin
			rd_sel_s1 <= cmd.pix_rd;
			if (cmd.col_zero) begin
				rx_found_q <= 1'b0;
			end else if (cmd.px_update && edge_w) begin
				rx_found_q <= 1'b1;
			end
			if (cmd.clear_found) begin
				row_found_q <= '0;
				col_found_q <= '0;
			end else begin
				if (cmd.px_update && edge_w) col_found_q[ci] <= 1'b1;
				if (cmd.row_commit && rx_found_q) row_found_q[ri] <= 1'b1;
			end
		end
	end

	assign row_hit = row_found_q[ri];
	assign col_hit = col_found_q[ci];

	always_comb begin
		res_d = '0;
		case (op_q)
			OP_COMPUTE: begin
				res_d.done_res = 1'b1;
			end
			OP_WRITE: begin
				res_d.out_of_range = oor;
				res_d.done_res = !oor;
			end
			OP_QUERY: begin
				if (oor) begin
					res_d.out_of_range = 1'b1;
				end else begin
					res_d.row_found = row_hit;
					res_d.row_first_col = row_hit ? row_rdata[EXT_W-1:IDX_W] : '0;
					res_d.row_last_col = row_hit ? row_rdata[IDX_W-1:0] : '0;
					res_d.col_found = col_hit;
					res_d.col_first_row = col_hit ? col_rdata[EXT_W-1:IDX_W] : '0;
					res_d.col_last_row = col_hit ? col_rdata[IDX_W-1:0] : '0;
					res_d.edge_bit = edge_w;
					res_d.boundary_bit = (row_hit && (col_q == row_rdata[EXT_W-1:IDX_W]
						|| col_q == row_rdata[IDX_W-1:0]))
						|| (col_hit && (row_q == col_rdata[EXT_W-1:IDX_W]
						|| row_q == col_rdata[IDX_W-1:0]));
					res_d.done_res = 1'b1;
				end
			end
			default: ;
		endcase
	end

	assign res = res_q;
endmodule

>>> design/binary_boundary_extreme_finder.sv
// ----------------------------------------------------------------------------
// binary_boundary_extreme_finder
// A pixel write loads the three window rows and then writes its row back; a
// query loads the window rows; an index outside the frame or an unknown op goes
// straight to the result. A compute walk visits every pixel of the W x H frame
// row by row, paced by the per-pixel read-modify-write of the column extreme memory.
// One item is worked on at a time; a new item is taken only once the result
// of the last is loaded. Reset clears the frame size to 256x256 and all found
// flags at once; the pixel bitmap holds no reset value.
// ----------------------------------------------------------------------------
module binary_boundary_extreme_finder #(
	parameter int MAX_WIDTH = bbef_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = bbef_pkg::DEF_MAX_HEIGHT
) (
	input logic clk,
	input logic arst_n,
	bbef_req_if.sink req,
	bbef_rsp_if.source rsp,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [bbef_pkg::APB_AW-1:0] paddr,
	input logic [bbef_pkg::APB_DW-1:0] pwdata,
	output logic [bbef_pkg::APB_DW-1:0] prdata,
	output logic pready
);
	import bbef_pkg::*;

	// The controller owns the handshakes and the sequence of each command;
	// the datapath owns the pixel memory, the three-row window that feeds the
	// 8-neighbour edge test, the row and column extreme memories with their
	// found flags, and the result register that parts the two channels.
	bbef_cmd_t cmd;
	bbef_sts_t sts;
	bbef_item_t item;
	bbef_res_t res;

	logic [SIZE_W-1:0] frame_width_q;
	logic [SIZE_W-1:0] frame_height_q;
	logic cfg_wr;

	// Configuration port. The register index sits at address bit 2, so
	// frame_width lives at byte address 0 and frame_height at byte address 4.
	// Writes complete in the access phase; there are no wait states.
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q <= FRAME_RESET;
			frame_height_q <= FRAME_RESET;
		end else if (cfg_wr) begin
			case (paddr[APB_AW-1])
				REG_FRAME_WIDTH: frame_width_q <= pwdata[SIZE_W-1:0];
				REG_FRAME_HEIGHT: frame_height_q <= pwdata[SIZE_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[APB_AW-1])
			REG_FRAME_WIDTH: prdata = APB_DW'(frame_width_q);
			REG_FRAME_HEIGHT: prdata = APB_DW'(frame_height_q);
			default: prdata = '0;
		endcase
	end

	// Command item as the datapath latches it on a transfer.
	assign item.op = req.op;
	assign item.row = req.row;
	assign item.col = req.col;
	assign item.pixel = req.pixel;

	bbef_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(req.valid),
		.in_ready(req.ready),
		.out_valid(rsp.valid),
		.out_ready(rsp.ready),
		.cmd(cmd),
		.sts(sts)
	);

	bbef_dp #(
		.MAX_WIDTH(MAX_WIDTH),
		.MAX_HEIGHT(MAX_HEIGHT)
	) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.sts(sts),
		.item(item),
		.frame_width(frame_width_q),
		.frame_height(frame_height_q),
		.res(res)
	);

	// Result fields straight from the result register.
	assign rsp.row_found = res.row_found;
	assign rsp.row_first_col = res.row_first_col;
	assign rsp.row_last_col = res.row_last_col;
	assign rsp.col_found = res.col_found;
	assign rsp.col_first_row = res.col_first_row;
	assign rsp.col_last_row = res.col_last_row;
	assign rsp.edge_bit = res.edge_bit;
	assign rsp.boundary_bit = res.boundary_bit;
	assign rsp.out_of_range = res.out_of_range;
	assign rsp.done_res = res.done_res;
endmodule

>>> design/bbef_checker.sv
// ----------------------------------------------------------------------------
// bbef_checker
// Port-level checks of the boundary extreme finder, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bbef_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic row_found,
	input logic [bbef_pkg::IDX_W-1:0] row_first_col,
	input logic [bbef_pkg::IDX_W-1:0] row_last_col,
	input logic col_found,
	input logic [bbef_pkg::IDX_W-1:0] col_first_row,
	input logic [bbef_pkg::IDX_W-1:0] col_last_row,
	input logic out_of_range,
	input logic done_res
);
	// A stalled result stays valid and keeps done, out_of_range, row_first_col and col_last_row.
	`BBEF_ASSERT_NEXT(a_rsp_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(done_res) && $stable(out_of_range) && $stable(row_first_col) && $stable(col_last_row), "stalled result changed")

	// One command at a time: a transfer makes the block busy.
	`BBEF_ASSERT_NEXT(a_busy_after_take, clk, arst_n, in_valid && in_ready, !in_ready, "command taken while busy")

	// An ignored index never also reports completion.
	`BBEF_ASSERT_IMPL(a_oor_excl, clk, arst_n, out_valid, !(done_res && out_of_range), "done and out of range together")

	// Extremes of a row or column without edges read as zero.
	`BBEF_ASSERT_IMPL(a_row_zero, clk, arst_n, out_valid && !row_found, row_first_col == '0 && row_last_col == '0, "row extremes without edge")
	`BBEF_ASSERT_IMPL(a_col_zero, clk, arst_n, out_valid && !col_found, col_first_row == '0 && col_last_row == '0, "column extremes without edge")
endmodule

bind binary_boundary_extreme_finder bbef_checker u_bbef_checker (
	.clk(clk),
	.arst_n(arst_n),
	.in_valid(req.valid),
	.in_ready(req.ready),
	.out_valid(rsp.valid),
	.out_ready(rsp.ready),
	.row_found(rsp.row_found),
	.row_first_col(rsp.row_first_col),
	.row_last_col(rsp.row_last_col),
	.col_found(rsp.col_found),
	.col_first_row(rsp.col_first_row),
	.col_last_row(rsp.col_last_row),
	.out_of_range(rsp.out_of_range),
	.done_res(rsp.done_res)
);
